/* rtl/gyro_bias_calibrate_yaw_integrate_macros.svh */
// assertion helpers used by the rtl top level
`ifndef GYRO_BIAS_CALIBRATE_YAW_INTEGRATE_MACROS_SVH
`define GYRO_BIAS_CALIBRATE_YAW_INTEGRATE_MACROS_SVH

// checked only while out of reset
`define GBCY_ASSERT(name, prop, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define GBCY_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

/* rtl/gbcy_pkg.sv */
`default_nettype none

package gbcy_pkg;

    // field widths
    localparam int RATE_W    = 16;
    localparam int STAMP_W   = 48;
    localparam int YAW_W     = 31;
    localparam int GATE_W    = 15;
    localparam int MAXDT_W   = 20;
    localparam int CFG_W     = 20;
    localparam int CFG_IDX_W = 1;

    // default calibration length
    localparam int SAMPLES_DEF = 64;

    // register reset values
    localparam logic [GATE_W-1:0]  NOISE_GATE_RST = GATE_W'(205);
    localparam logic [MAXDT_W-1:0] MAX_DT_RST     = MAXDT_W'(500000);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_NOISE_GATE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DT     = 1'b1;

    // integration datapath widths
    localparam int DT_W    = STAMP_W + 1;
    localparam int DIFF_W  = RATE_W + 1;
    localparam int P1_W    = DIFF_W + MAXDT_W + 1;
    localparam int SCALE_W = 14;
    localparam int P2_W    = P1_W + SCALE_W;
    localparam int FRAC_SH = 16;
    localparam int INC_W   = P2_W - FRAC_SH;
    localparam int ACC_W   = INC_W + 1;

    // us-to-q28 scale factor in q16
    localparam logic signed [SCALE_W-1:0] DT_SCALE = SCALE_W'(4295);

    // angle limits in q3.28
    localparam logic signed [ACC_W-1:0] PI_ACC     = ACC_W'(843314857);
    localparam logic signed [ACC_W-1:0] NEG_PI_ACC = -PI_ACC;
    localparam logic signed [ACC_W-1:0] TWO_PI_ACC = ACC_W'(1686629713);

    // operating phase
    typedef enum logic [1:0] {
        PH_CAL,
        PH_AWAIT,
        PH_RUN
    } t_phase;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CAL,
        ST_CHECK,
        ST_DIV,
        ST_BIAS,
        ST_MUL1,
        ST_MUL2,
        ST_ADD,
        ST_WRAP
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic stamp_store;
        logic accumulate;
        logic div_load;
        logic div_step;
        logic bias_store;
        logic mul1;
        logic mul2;
        logic add;
        logic wrap_step;
        logic commit;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic count_full;
        logic dt_ok;
        logic wrap_hi;
        logic wrap_lo;
        logic out_free;
    } t_stat;

endpackage

`default_nettype wire

/* rtl/gbcy_ctrl.sv */
`default_nettype none

module gbcy_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  gbcy_pkg::t_stat   i_stat,
    output gbcy_pkg::t_cmd    o_cmd
);
    import gbcy_pkg::*;

    t_state r_state, n_state;
    t_phase r_phase, n_phase;
    logic   w_wrapping;

    assign w_wrapping = i_stat.wrap_hi || i_stat.wrap_lo;

    // state and phase registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_phase <= PH_CAL;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    case (r_phase)
                        PH_CAL:   n_state = ST_CAL;
                        PH_AWAIT: n_phase = PH_RUN;
                        PH_RUN:   n_state = ST_MUL1;
                        default:  n_phase = PH_CAL;
                    endcase
                end
            end
            ST_CAL:   n_state = ST_CHECK;
            ST_CHECK: n_state = i_stat.count_full ? ST_DIV : ST_IDLE;
            ST_DIV:   n_state = ST_BIAS;
            ST_BIAS: begin
                n_phase = PH_AWAIT;
                n_state = ST_IDLE;
            end
            ST_MUL1:  n_state = i_stat.dt_ok ? ST_MUL2 : ST_IDLE;
            ST_MUL2:  n_state = ST_ADD;
            ST_ADD:   n_state = ST_WRAP;
            ST_WRAP: begin
                if (!w_wrapping && i_stat.out_free) n_state = ST_IDLE;
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    // commands
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready        = 1'b1;
                o_cmd.capture     = i_in_valid;
                o_cmd.stamp_store = i_in_valid && (r_phase != PH_CAL);
            end
            ST_CAL:   o_cmd.accumulate = 1'b1;
            ST_CHECK: o_cmd.div_load   = i_stat.count_full;
            ST_DIV:   o_cmd.div_step   = 1'b1;
            ST_BIAS:  o_cmd.bias_store = 1'b1;
            ST_MUL1:  o_cmd.mul1       = i_stat.dt_ok;
            ST_MUL2:  o_cmd.mul2       = 1'b1;
            ST_ADD:   o_cmd.add        = 1'b1;
            ST_WRAP: begin
                o_cmd.wrap_step = w_wrapping;
                o_cmd.commit    = !w_wrapping && i_stat.out_free;
            end
            default:  o_cmd = '0;
        endcase
    end

endmodule

`default_nettype wire

/* rtl/gbcy_dp.sv */
`default_nettype none

module gbcy_dp #(
    parameter int SAMPLES = gbcy_pkg::SAMPLES_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic        [gbcy_pkg::CFG_IDX_W-1:0] i_cfg_addr,
    input  logic        [gbcy_pkg::CFG_W-1:0]     i_cfg_wdata,
    input  logic signed [gbcy_pkg::RATE_W-1:0]    i_gyro_rate,
    input  logic        [gbcy_pkg::STAMP_W-1:0]   i_stamp_us,
    output logic signed [gbcy_pkg::YAW_W-1:0]     o_yaw,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    input  gbcy_pkg::t_cmd                        i_cmd,
    output gbcy_pkg::t_stat                       o_stat
);
    import gbcy_pkg::*;

    localparam int CNT_W  = $clog2(SAMPLES + 1);
    localparam int SUM_W  = RATE_W + $clog2(SAMPLES);
    // reciprocal of the sample count, exact floor for any SUM_W-bit dividend
    localparam int RCP_SH = SUM_W + $clog2(SAMPLES);
    localparam int RCP_W  = SUM_W + 2;
    localparam int PROD_W = SUM_W + RCP_W;
    localparam logic [RCP_W-1:0] RCP =
        RCP_W'(((64'd1 << RCP_SH) + 64'(SAMPLES) - 64'd1) / 64'(SAMPLES));

    // configuration
    logic [GATE_W-1:0]  r_noise_gate;
    logic [MAXDT_W-1:0] r_max_dt;

    // captured sample
    logic signed [RATE_W-1:0] r_rate;
    logic signed [DIFF_W-1:0] r_diff, n_diff;
    logic        [DT_W-1:0]   r_dt, n_dt;
    logic        [STAMP_W-1:0] r_last_stamp;

    // calibration
    logic        [CNT_W-1:0]  r_count;
    logic signed [SUM_W-1:0]  r_sum;
    logic signed [RATE_W-1:0] r_bias;
    logic        [DIFF_W-1:0] w_rate_x, w_mag;
    logic                     w_pass;

    // mean
    logic              r_div_neg;
    logic [SUM_W-1:0]  r_div_x, r_div_q, w_sum_mag, w_bias_full;
    logic [PROD_W-1:0] w_prod;

    // integration
    logic signed [P1_W-1:0]  r_p1, n_p1;
    logic signed [P2_W-1:0]  r_p2, n_p2;
    logic signed [INC_W-1:0] w_inc;
    logic signed [ACC_W-1:0] r_acc, n_acc_sum;
    logic signed [YAW_W-1:0] r_heading, r_out;
    logic                    r_out_valid;

    // config write port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_noise_gate <= NOISE_GATE_RST;
            r_max_dt     <= MAX_DT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_NOISE_GATE: r_noise_gate <= i_cfg_wdata[GATE_W-1:0];
                CFG_MAX_DT:     r_max_dt     <= i_cfg_wdata[MAXDT_W-1:0];
                default:        r_max_dt     <= r_max_dt;
            endcase
        end
    end

    // rate minus bias and time step, formed as the transaction is taken
    assign n_diff = {i_gyro_rate[RATE_W-1], i_gyro_rate} - {r_bias[RATE_W-1], r_bias};
    assign n_dt   = {1'b0, i_stamp_us} - {1'b0, r_last_stamp};

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_rate <= i_gyro_rate;
            r_diff <= n_diff;
            r_dt   <= n_dt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_last_stamp <= '0;
        else if (i_cmd.stamp_store) r_last_stamp <= i_stamp_us;
    end

    // stationary gate on the magnitude
    assign w_rate_x = {r_rate[RATE_W-1], r_rate};
    assign w_mag    = w_rate_x[DIFF_W-1] ? (DIFF_W'(0) - w_rate_x) : w_rate_x;
    assign w_pass   = w_mag < {{(DIFF_W-GATE_W){1'b0}}, r_noise_gate};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_sum   <= '0;
        end else if (i_cmd.accumulate && w_pass) begin
            r_count <= r_count + CNT_W'(1);
            r_sum   <= r_sum + {{(SUM_W-RATE_W){r_rate[RATE_W-1]}}, r_rate};
        end
    end

    // floor mean by reciprocal multiply; a negative sum divides |sum| + SAMPLES - 1
    assign w_sum_mag = r_sum[SUM_W-1] ? (SUM_W'(0) - r_sum) : r_sum;
    assign w_prod    = PROD_W'(r_div_x) * PROD_W'(RCP);

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_load) begin
            r_div_neg <= r_sum[SUM_W-1];
            r_div_x   <= r_sum[SUM_W-1] ? (w_sum_mag + SUM_W'(SAMPLES - 1)) : w_sum_mag;
        end else if (i_cmd.div_step) begin
            r_div_q <= SUM_W'(w_prod >> RCP_SH);
        end
    end

    // restore the sign of the mean
    assign w_bias_full = r_div_neg ? (SUM_W'(0) - r_div_q) : r_div_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_bias <= '0;
        else if (i_cmd.bias_store) r_bias <= w_bias_full[RATE_W-1:0];
    end

    // two multiply stages, then the heading add
    assign n_p1 = r_diff * $signed({1'b0, r_dt[MAXDT_W-1:0]});
    assign n_p2 = r_p1 * DT_SCALE;
    assign w_inc = r_p2[P2_W-1:FRAC_SH];
    assign n_acc_sum = {{(ACC_W-YAW_W){r_heading[YAW_W-1]}}, r_heading}
                     + {{(ACC_W-INC_W){w_inc[INC_W-1]}}, w_inc};

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul1) r_p1 <= n_p1;
        if (i_cmd.mul2) r_p2 <= n_p2;
    end

    // one 2pi step per cycle until in range
    always_ff @(posedge i_clk) begin
        if (i_cmd.add) r_acc <= n_acc_sum;
        else if (i_cmd.wrap_step) begin
            r_acc <= o_stat.wrap_hi ? (r_acc - TWO_PI_ACC) : (r_acc + TWO_PI_ACC);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_heading <= '0;
        else if (i_cmd.commit) r_heading <= r_acc[YAW_W-1:0];
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) r_out <= r_acc[YAW_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_out_valid <= 1'b0;
        else if (i_cmd.commit) r_out_valid <= 1'b1;
        else if (i_out_ready) r_out_valid <= 1'b0;
    end

    assign o_yaw       = r_out;
    assign o_out_valid = r_out_valid;

    // status
    always_comb begin
        o_stat            = '0;
        o_stat.count_full = r_count == CNT_W'(SAMPLES);
        o_stat.dt_ok      = !r_dt[DT_W-1] && (r_dt != '0)
                         && (r_dt <= {{(DT_W-MAXDT_W){1'b0}}, r_max_dt});
        o_stat.wrap_hi    = r_acc > PI_ACC;
        o_stat.wrap_lo    = r_acc <= NEG_PI_ACC;
        o_stat.out_free   = !r_out_valid || i_out_ready;
    end

endmodule

`default_nettype wire

/* rtl/gyro_bias_calibrate_yaw_integrate.sv */
// Gyro yaw integrator with start-up bias calibration. Samples (Q4.12 z rate, 48-bit
// microsecond stamp) enter on a valid/ready channel, one at a time; yaw results in
// Q3.28 radians within (-pi, pi] leave through an output register, so the next
// sample is taken while a result waits. During calibration a sample goes through
// capture, accumulate and check; the one that completes the count adds the reciprocal
// multiply that forms the mean and the bias store. The sample after calibration only
// records its stamp. A running sample goes through capture with dt subtract, rate*dt
// multiply, scale multiply, heading add and wrap check, plus one 2pi wrap step at a
// time until in range, and waits while the output register is full. Samples with dt
// outside (0, max_dt] end with no result. Configuration is to be written through
// i_cfg_we/i_cfg_addr/i_cfg_wdata only while idle; the block does not enforce this.
`default_nettype none
`include "gyro_bias_calibrate_yaw_integrate_macros.svh"

module gyro_bias_calibrate_yaw_integrate #(
    parameter int SAMPLES = gbcy_pkg::SAMPLES_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic        [gbcy_pkg::CFG_IDX_W-1:0] i_cfg_addr,
    input  logic        [gbcy_pkg::CFG_W-1:0]     i_cfg_wdata,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic signed [gbcy_pkg::RATE_W-1:0]    i_gyro_rate,
    input  logic        [gbcy_pkg::STAMP_W-1:0]   i_stamp_us,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic signed [gbcy_pkg::YAW_W-1:0]     o_yaw
);
    import gbcy_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;
    logic signed [ACC_W-1:0] w_yaw_x;

    // sequencer
    gbcy_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // arithmetic and state
    gbcy_dp #(
        .SAMPLES (SAMPLES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_gyro_rate (i_gyro_rate),
        .i_stamp_us  (i_stamp_us),
        .o_yaw       (o_yaw),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat)
    );

    assign w_yaw_x = $signed({{(ACC_W-YAW_W){o_yaw[YAW_W-1]}}, o_yaw});

    // checks
    `GBCY_ASSERT(a_commit_free, w_cmd.commit |-> w_stat.out_free, "commit into full output register")
    `GBCY_ASSERT(a_commit_shows, w_cmd.commit |=> o_out_valid, "committed yaw not presented")
    `GBCY_ASSERT(a_yaw_range, o_out_valid |-> (w_yaw_x <= PI_ACC && w_yaw_x > NEG_PI_ACC), "yaw out of range")
    `GBCY_ASSERT_ALWAYS(a_rst_idle, !i_rst_n |=> !o_out_valid, "output valid after reset")

endmodule

`default_nettype wire
